@@ rtl/core/multi_queue_byte_fifo_macros.svh @@
// assertion macros used by the top rtl file of the queue pool
`ifndef MULTI_QUEUE_BYTE_FIFO_MACROS_SVH
`define MULTI_QUEUE_BYTE_FIFO_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MQBF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mqbf check failed");

// next-cycle implication
`define MQBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mqbf check failed");

`else

`define MQBF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MQBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/mqbf_pkg.sv @@
package mqbf_pkg;

    localparam int KIND_W   = 3;
    localparam int ID_W     = 4;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int GRANT_W  = 4;
    localparam int COUNT_W  = 12;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    // create only looks at queues whose number fits in queue_id
    localparam int ID_LIMIT = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;

    localparam logic [KIND_W-1:0] KIND_CREATE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_FETCH = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // first member sits in the highest bits, so status lands at bit 0
    typedef struct packed {
        logic [COUNT_W-1:0]  space;
        logic [COUNT_W-1:0]  held;
        logic [GRANT_W-1:0]  granted;
        logic [BYTE_W-1:0]   rbyte;
        logic [STATUS_W-1:0] status;
    } t_result;

    typedef struct packed {
        logic claim;
        logic free;
    } t_alloc_op;

endpackage

@@ rtl/core/mqbf_ram.sv @@
module mqbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/mqbf_alloc.sv @@
module mqbf_alloc #(
    parameter int QUEUES = 16,
    parameter int QW     = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mqbf_pkg::t_alloc_op i_op,
    input  logic [QW-1:0]       i_idx,
    input  logic [QW-1:0]       i_probe,
    output logic                o_open_hit,
    output logic                o_found,
    output logic [QW-1:0]       o_free_idx
);

    localparam int LIMIT = (QUEUES < mqbf_pkg::ID_LIMIT) ? QUEUES : mqbf_pkg::ID_LIMIT;

    logic [QUEUES-1:0] r_open;
    logic [QUEUES-1:0] n_open;

    always_comb begin
        n_open = r_open;
        if (i_op.claim) begin
            n_open[i_idx] = 1'b1;
        end else if (i_op.free) begin
            n_open[i_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= n_open;
        end
    end

    // lowest-numbered free queue wins
    always_comb begin
        o_found    = 1'b0;
        o_free_idx = '0;
        for (int i = LIMIT - 1; i >= 0; i--) begin
            if (!r_open[i]) begin
                o_found    = 1'b1;
                o_free_idx = QW'(i);
            end
        end
    end

    assign o_open_hit = r_open[i_probe];

endmodule

@@ rtl/core/multi_queue_byte_fifo.sv @@
// channel  dir  tuser        tdata (low bit first)
// s_axis   in   kind [2:0]   queue_id [3:0], write_byte [11:4]
// m_axis   out  -            status [2:0], read_byte [10:3], granted_queue [14:11],
//                            bytes_held [26:15], space_free [38:27], zero [39]
//
// an item passes through the idle, pointer lookup and done steps; a read that returns
// a byte adds a fetch step, as the pointer memory read and then the byte store read come first.
// the next item is taken while the previous result still waits in the output register.
// a result stalls in the done step only while the output register is still held.
// reset clears the allocation flags; both memories start undefined and need no
// clearing pass, since pointers are written by create before any use.
`include "multi_queue_byte_fifo_macros.svh"

module multi_queue_byte_fifo #(
    parameter int QUEUES      = 16,
    parameter int QUEUE_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // queue_id, write_byte
    input  logic [2:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status, read_byte, granted_queue, bytes_held,
                                        // space_free
);

    localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int PW  = $clog2(QUEUE_BYTES);
    localparam int SAW = QW + PW;
    localparam int CW  = PW + 1;
    localparam int STORE_DEPTH = 1 << SAW;

    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_BYTES - 1);
    localparam logic [CW-1:0] QB_C      = CW'(QUEUE_BYTES);

    mqbf_pkg::t_state  r_state, n_state;
    logic [2:0]        r_kind;
    logic [QW-1:0]     r_q;
    logic              r_in_range;
    logic [7:0]        r_wbyte;
    mqbf_pkg::t_result r_res, n_res;
    mqbf_pkg::t_result r_out;
    logic              r_m_valid;
    logic              r_read_ok, n_read_ok;

    logic          w_acc;
    logic [3:0]    w_in_id;
    logic          w_in_range;

    logic                w_ptr_we;
    logic [QW-1:0]       w_ptr_waddr;
    logic [2*PW-1:0]     w_ptr_wdata;
    logic [2*PW-1:0]     w_ptr_rdata;
    logic [PW-1:0]       w_rp, w_wp, w_rp_nx, w_wp_nx;

    logic                w_st_we, w_st_re;
    logic [7:0]          w_st_rdata;

    mqbf_pkg::t_alloc_op w_aop;
    logic [QW-1:0]       w_aidx;
    logic                w_open_hit, w_found;
    logic [QW-1:0]       w_free_idx;

    logic [PW-1:0]       w_hr, w_hw;
    logic                w_report;
    logic [CW-1:0]       w_diff, w_held, w_space;
    logic [11:0]         w_held12, w_space12;

    assign w_acc      = s_axis_tvalid & s_axis_tready;
    assign w_in_id    = s_axis_tdata[3:0];
    assign w_in_range = (32'(w_in_id) < QUEUES);

    assign s_axis_tready = (r_state == mqbf_pkg::S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    mqbf_ram #(
        .WIDTH (2 * PW),
        .DEPTH (QUEUES)
    ) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (w_ptr_we),
        .i_waddr (w_ptr_waddr),
        .i_wdata (w_ptr_wdata),
        .i_re    (w_acc & w_in_range),
        .i_raddr (QW'(w_in_id)),
        .o_rdata (w_ptr_rdata)
    );

    mqbf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr ({r_q, w_wp}),
        .i_wdata (r_wbyte),
        .i_re    (w_st_re),
        .i_raddr ({r_q, w_rp}),
        .o_rdata (w_st_rdata)
    );

    mqbf_alloc #(
        .QUEUES (QUEUES),
        .QW     (QW)
    ) u_alloc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_aop),
        .i_idx      (w_aidx),
        .i_probe    (r_q),
        .o_open_hit (w_open_hit),
        .o_found    (w_found),
        .o_free_idx (w_free_idx)
    );

    assign w_rp    = w_ptr_rdata[2*PW-1:PW];
    assign w_wp    = w_ptr_rdata[PW-1:0];
    assign w_rp_nx = (w_rp == LAST_SLOT) ? '0 : w_rp + 1'b1;
    assign w_wp_nx = (w_wp == LAST_SLOT) ? '0 : w_wp + 1'b1;

    // ring distance, wrapped by adding the queue size
    assign w_diff    = {1'b0, w_hw} - {1'b0, w_hr};
    assign w_held    = w_diff[PW] ? w_diff + QB_C : w_diff;
    assign w_space   = QB_C - 1'b1 - w_held;
    assign w_held12  = (32'(w_held) > 32'(mqbf_pkg::COUNT_MAX)) ? mqbf_pkg::COUNT_MAX
                                                                 : 12'(w_held);
    assign w_space12 = (32'(w_space) > 32'(mqbf_pkg::COUNT_MAX)) ? mqbf_pkg::COUNT_MAX
                                                                  : 12'(w_space);

    always_comb begin
        w_aop       = '0;
        w_aidx      = r_q;
        w_ptr_we    = 1'b0;
        w_ptr_waddr = r_q;
        w_ptr_wdata = '0;
        w_st_we     = 1'b0;
        w_st_re     = 1'b0;
        w_hr        = w_rp;
        w_hw        = w_wp;
        w_report    = 1'b0;
        n_read_ok   = 1'b0;
        n_res       = '0;
        if (r_state == mqbf_pkg::S_LOOK) begin
            if (r_kind == mqbf_pkg::KIND_CREATE) begin
                if (w_found) begin
                    w_aop.claim = 1'b1;
                    w_aidx      = w_free_idx;
                    w_ptr_we    = 1'b1;
                    w_ptr_waddr = w_free_idx;
                    n_res.granted = 4'(w_free_idx);
                    w_hr        = '0;
                    w_hw        = '0;
                    w_report    = 1'b1;
                end else begin
                    n_res.status = mqbf_pkg::ST_NO_FREE;
                end
            end else if (!r_in_range || !w_open_hit) begin
                n_res.status = mqbf_pkg::ST_NOT_ALLOC;
            end else begin
                case (r_kind)
                    mqbf_pkg::KIND_WRITE: begin
                        w_report = 1'b1;
                        if (w_wp_nx == w_rp) begin
                            n_res.status = mqbf_pkg::ST_FULL;
                        end else begin
                            w_st_we     = 1'b1;
                            w_ptr_we    = 1'b1;
                            w_ptr_wdata = {w_rp, w_wp_nx};
                            w_hw        = w_wp_nx;
                        end
                    end
                    mqbf_pkg::KIND_READ: begin
                        w_report = 1'b1;
                        if (w_rp == w_wp) begin
                            n_res.status = mqbf_pkg::ST_EMPTY;
                        end else begin
                            w_st_re     = 1'b1;
                            n_read_ok   = 1'b1;
                            w_ptr_we    = 1'b1;
                            w_ptr_wdata = {w_rp_nx, w_wp};
                            w_hr        = w_rp_nx;
                        end
                    end
                    mqbf_pkg::KIND_CLOSE: begin
                        w_aop.free = 1'b1;
                        w_ptr_we   = 1'b1;
                    end
                    default: begin
                        // query, and the unused kinds that behave as query
                        w_report = 1'b1;
                    end
                endcase
            end
            if (w_report) begin
                n_res.held  = w_held12;
                n_res.space = w_space12;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mqbf_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_state = mqbf_pkg::S_LOOK;
                end
            end
            mqbf_pkg::S_LOOK: begin
                n_state = n_read_ok ? mqbf_pkg::S_FETCH : mqbf_pkg::S_DONE;
            end
            mqbf_pkg::S_FETCH: begin
                n_state = mqbf_pkg::S_DONE;
            end
            mqbf_pkg::S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = mqbf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mqbf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mqbf_pkg::S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mqbf_pkg::S_DONE && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_kind     <= s_axis_tuser;
            r_q        <= QW'(w_in_id);
            r_in_range <= w_in_range;
            r_wbyte    <= s_axis_tdata[11:4];
        end
        if (r_state == mqbf_pkg::S_LOOK) begin
            r_res     <= n_res;
            r_read_ok <= n_read_ok;
        end
        if (r_state == mqbf_pkg::S_FETCH && r_read_ok) begin
            r_res.rbyte <= w_st_rdata;
        end
        if (r_state == mqbf_pkg::S_DONE && (!r_m_valid || m_axis_tready)) begin
            r_out <= r_res;
        end
    end

    `MQBF_ASSERT_NEXT(a_accept_looks, i_clk, i_rst_n, w_acc, r_state == mqbf_pkg::S_LOOK)
    `MQBF_ASSERT_IMPL(a_fetch_after_read, i_clk, i_rst_n,
        r_state == mqbf_pkg::S_FETCH, $past(w_st_re))
    `MQBF_ASSERT_IMPL(a_store_one_port, i_clk, i_rst_n, w_st_we, !w_st_re)
    `MQBF_ASSERT_IMPL(a_grant_only_ok, i_clk, i_rst_n,
        r_m_valid && r_out.status != mqbf_pkg::ST_OK, r_out.granted == '0)

endmodule

@@ dv/tb_multi_queue_byte_fifo.sv @@
`timescale 1ns / 100ps

module tb_multi_queue_byte_fifo;

    localparam int NUM_QUEUES  = 16;
    localparam int SLOTS       = 4096;
    localparam int STALL_LIMIT = 3000;

    class pool_scoreboard;
        bit [7:0]  ring_bytes [NUM_QUEUES][SLOTS];
        int        rd_ptr [NUM_QUEUES];
        int        wr_ptr [NUM_QUEUES];
        bit        is_open [NUM_QUEUES];
        mqbf_pkg::t_result replies_due [$];
        int        errors;

        function new();
            for (int q = 0; q < NUM_QUEUES; q++) begin
                rd_ptr[q] = 0;
                wr_ptr[q] = 0;
                is_open[q] = 0;
            end
            errors = 0;
        endfunction

        function int held_in(int q);
            return (wr_ptr[q] >= rd_ptr[q]) ? wr_ptr[q] - rd_ptr[q]
                                            : wr_ptr[q] + SLOTS - rd_ptr[q];
        endfunction

        function int next_slot(int p);
            return (p + 1 >= SLOTS) ? 0 : p + 1;
        endfunction

        function logic [mqbf_pkg::COUNT_W-1:0] sat_count(int v);
            return (v > 4095) ? mqbf_pkg::COUNT_MAX : mqbf_pkg::COUNT_W'(v);
        endfunction

        // work out the reply to one accepted request and queue it up
        function void note_request(logic [2:0] kind, logic [3:0] qid, logic [7:0] wbyte);
            mqbf_pkg::t_result r;
            int q;
            bit counts;
            r = '0;
            q = qid;
            counts = 1;
            if (kind == mqbf_pkg::KIND_CREATE) begin
                q = -1;
                for (int i = 0; i < NUM_QUEUES && i < mqbf_pkg::ID_LIMIT; i++) begin
                    if (!is_open[i] && q < 0) q = i;
                end
                if (q < 0) begin
                    r.status = mqbf_pkg::ST_NO_FREE;
                    counts = 0;
                end else begin
                    is_open[q] = 1;
                    rd_ptr[q] = 0;
                    wr_ptr[q] = 0;
                    r.granted = mqbf_pkg::GRANT_W'(q);
                end
            end else if (q >= NUM_QUEUES || !is_open[q]) begin
                r.status = mqbf_pkg::ST_NOT_ALLOC;
                counts = 0;
            end else if (kind == mqbf_pkg::KIND_WRITE) begin
                if (next_slot(wr_ptr[q]) == rd_ptr[q]) begin
                    r.status = mqbf_pkg::ST_FULL;
                end else begin
                    ring_bytes[q][wr_ptr[q]] = wbyte;
                    wr_ptr[q] = next_slot(wr_ptr[q]);
                end
            end else if (kind == mqbf_pkg::KIND_READ) begin
                if (rd_ptr[q] == wr_ptr[q]) begin
                    r.status = mqbf_pkg::ST_EMPTY;
                end else begin
                    r.rbyte = ring_bytes[q][rd_ptr[q]];
                    rd_ptr[q] = next_slot(rd_ptr[q]);
                end
            end else if (kind == mqbf_pkg::KIND_CLOSE) begin
                is_open[q] = 0;
                rd_ptr[q] = 0;
                wr_ptr[q] = 0;
                counts = 0;
            end
            // query and the unused kinds change nothing
            if (counts) begin
                r.held  = sat_count(held_in(q));
                r.space = sat_count(SLOTS - 1 - held_in(q));
            end
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [39:0] data);
            mqbf_pkg::t_result want;
            mqbf_pkg::t_result got;
            got = mqbf_pkg::t_result'(data[38:0]);
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected reply, actual %h", $time, data);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.rbyte !== want.rbyte) begin
                $display("%0t: read_byte expected %h actual %h", $time, want.rbyte, got.rbyte);
                errors++;
            end
            if (got.granted !== want.granted) begin
                $display("%0t: granted_queue expected %0d actual %0d", $time,
                         want.granted, got.granted);
                errors++;
            end
            if (got.held !== want.held) begin
                $display("%0t: bytes_held expected %0d actual %0d", $time, want.held, got.held);
                errors++;
            end
            if (got.space !== want.space) begin
                $display("%0t: space_free expected %0d actual %0d", $time,
                         want.space, got.space);
                errors++;
            end
            if (data[39] !== 1'b0) begin
                $display("%0t: pad bit expected 0 actual %b", $time, data[39]);
                errors++;
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        // random open queue, or -1 when none is open
        function int pick_open();
            int open_ids [$];
            for (int q = 0; q < NUM_QUEUES; q++) begin
                if (is_open[q]) open_ids.push_back(q);
            end
            if (open_ids.size() == 0) return -1;
            return open_ids[$urandom_range(0, open_ids.size() - 1)];
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // queue_id, write_byte
    logic [2:0]  s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // status, read_byte, granted_queue, bytes_held, space_free

    pool_scoreboard sb;
    bit idle_on;
    int stall_cycles;

    multi_queue_byte_fifo uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // both handshakes sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[11:4]);
        end
    end

    initial begin
        stall_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver back-pressure in bursts while idle_on is set
    initial begin
        int hold;
        m_axis_tready = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                hold = $urandom_range(0, 10);
            end else begin
                m_axis_tready <= 1'b1;
                hold = $urandom_range(0, 19);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task send_item(input logic [2:0] kind, input logic [3:0] qid, input logic [7:0] wbyte);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, wbyte, qid};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task run_directed();
        for (int i = 0; i < NUM_QUEUES; i++)
            send_item(mqbf_pkg::KIND_CREATE, 4'($urandom), 8'h00);
        send_item(mqbf_pkg::KIND_CREATE, 4'hF, 8'hFF);           // pool exhausted
        send_item(mqbf_pkg::KIND_WRITE, 4'd3, 8'hFF);
        send_item(mqbf_pkg::KIND_WRITE, 4'd3, 8'h00);
        send_item(mqbf_pkg::KIND_READ,  4'd3, 8'h00);
        send_item(mqbf_pkg::KIND_READ,  4'd3, 8'hFF);
        send_item(mqbf_pkg::KIND_READ,  4'd3, 8'h5A);            // empty now
        send_item(mqbf_pkg::KIND_QUERY, 4'd3, 8'hA5);
        send_item(mqbf_pkg::KIND_CLOSE, 4'd5, 8'h00);
        send_item(mqbf_pkg::KIND_CLOSE, 4'd15, 8'h00);
        send_item(mqbf_pkg::KIND_CREATE, 4'd0, 8'h00);           // lowest free is 5
        send_item(mqbf_pkg::KIND_WRITE, 4'd15, 8'h81);           // closed queue
        send_item(mqbf_pkg::KIND_READ,  4'd15, 8'h00);
        send_item(mqbf_pkg::KIND_CLOSE, 4'd15, 8'h00);
        send_item(3'd5, 4'd0, 8'h00);
        send_item(3'd6, 4'd15, 8'hFF);
        send_item(3'd7, 4'd5, 8'h00);
    endtask

    // long burst of writes into one queue, then drain it past empty
    task run_fill();
        int q;
        q = sb.pick_open();
        if (q < 0) begin
            send_item(mqbf_pkg::KIND_CREATE, 4'd0, 8'h00);
            q = sb.pick_open();
        end
        repeat (120) send_item(mqbf_pkg::KIND_WRITE, 4'(q), 8'($urandom));
        send_item(mqbf_pkg::KIND_QUERY, 4'(q), 8'h00);
        repeat (125) send_item(mqbf_pkg::KIND_READ, 4'(q), 8'($urandom));
        send_item(mqbf_pkg::KIND_CLOSE, 4'(q), 8'h00);
    endtask

    task run_random(input int count, input bit with_pause);
        int pick;
        int q;
        logic [2:0] kind;
        for (int i = 0; i < count; i++) begin
            if (with_pause && i == count / 2) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 8)       kind = mqbf_pkg::KIND_CREATE;
            else if (pick < 43) kind = mqbf_pkg::KIND_WRITE;
            else if (pick < 73) kind = mqbf_pkg::KIND_READ;
            else if (pick < 83) kind = mqbf_pkg::KIND_QUERY;
            else if (pick < 90) kind = mqbf_pkg::KIND_CLOSE;
            else                kind = 3'($urandom_range(5, 7));
            q = sb.pick_open();
            if (q < 0 || $urandom_range(0, 99) < 15) q = $urandom_range(0, NUM_QUEUES - 1);
            send_item(kind, 4'(q), 8'($urandom));
        end
    endtask

    initial begin
        sb = new();
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        run_fill();
        run_random(400, 1'b1);
        idle_on = 1'b0;
        run_random(120, 1'b0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/mqbf_pkg.sv
rtl/core/mqbf_ram.sv
rtl/core/mqbf_alloc.sv
rtl/core/multi_queue_byte_fifo.sv
dv/tb_multi_queue_byte_fifo.sv
